@@ design/gbp_pkg.sv @@
// Shared constants and types of the gshare branch predictor.
`timescale 1ns / 1ps
`default_nettype none
package gbp_pkg;

  localparam int MAX_HISTORY_BITS = 12;
  localparam int HIST_LEN_W       = 4;
  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RST = 4'd12;

  localparam int CTR_W = 2;
  localparam logic [CTR_W-1:0] CTR_INIT = 2'd2;
  localparam logic [CTR_W-1:0] CTR_MAX  = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN  = 2'd0;
  localparam logic [CTR_W-1:0] CTR_STEP = 2'd1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_UPDATE
  } back_state_t;

endpackage
`default_nettype wire

@@ design/gbp_if.sv @@
// Channel interfaces: branch input and prediction result.
`timescale 1ns / 1ps
`default_nettype none
interface gbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_pc;
  logic        actual_taken;

  modport source (output valid, output branch_pc, output actual_taken, input ready);
  modport sink   (input valid, input branch_pc, input actual_taken, output ready);
endinterface

interface gbp_out_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic mispredicted;

  modport source (output valid, output predicted_taken, output mispredicted, input ready);
  modport sink   (input valid, input predicted_taken, input mispredicted, output ready);
endinterface
`default_nettype wire

@@ design/gbp_front.sv @@
// Front end: history register, config register and table index generation.
`timescale 1ns / 1ps
`default_nettype none
module gbp_front #(
  parameter int MAX_HISTORY_BITS = gbp_pkg::MAX_HISTORY_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [gbp_pkg::HIST_LEN_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [31:0]                   branch_pc,
  input  wire logic                          actual_taken,
  input  wire logic                          back_clearing,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output logic [MAX_HISTORY_BITS:0]          push_data
);

  logic [gbp_pkg::HIST_LEN_W-1:0] hist_len_r;
  logic [MAX_HISTORY_BITS-1:0]    history_r;
  logic [MAX_HISTORY_BITS-1:0]    history_nxt;
  logic [MAX_HISTORY_BITS-1:0]    idx_mask;
  logic [MAX_HISTORY_BITS-1:0]    idx;
  int unsigned                    len_eff;
  logic                           accept;

  // Saturate the configured length into 1..MAX_HISTORY_BITS.
  always_comb begin
    if (hist_len_r == '0) begin
      len_eff = 1;
    end else if (int'(hist_len_r) > MAX_HISTORY_BITS) begin
      len_eff = MAX_HISTORY_BITS;
    end else begin
      len_eff = int'(hist_len_r);
    end
    for (int i = 0; i < MAX_HISTORY_BITS; i++) begin
      idx_mask[i] = (i < len_eff);
    end
  end

  assign idx         = (branch_pc[MAX_HISTORY_BITS-1:0] ^ history_r) & idx_mask;
  assign in_ready    = push_ready && !back_clearing;
  assign accept      = in_valid && in_ready;
  assign push_valid  = in_valid && !back_clearing;
  assign push_data   = {idx, actual_taken};
  assign history_nxt = MAX_HISTORY_BITS'({history_r, actual_taken});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_len_r <= gbp_pkg::HIST_LEN_RST;
      history_r  <= '0;
    end else begin
      if (cfg_we) begin
        hist_len_r <= cfg_wdata;
      end
      if (accept) begin
        history_r <= history_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/gbp_queue.sv @@
// Small FIFO between front end and counter update engine.
`timescale 1ns / 1ps
`default_nettype none
module gbp_queue #(
  parameter int DATA_W = gbp_pkg::MAX_HISTORY_BITS + 1,
  parameter int DEPTH  = gbp_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ design/gbp_back.sv @@
// Back end: counter table memory, clearing sweep, read-modify-write and output register.
`timescale 1ns / 1ps
`default_nettype none
module gbp_back #(
  parameter int MAX_HISTORY_BITS = gbp_pkg::MAX_HISTORY_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  output logic                           clearing,
  input  wire logic                      pop_valid,
  output logic                           pop_ready,
  input  wire logic [MAX_HISTORY_BITS:0] pop_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           predicted_taken,
  output logic                           mispredicted
);

  localparam int DEPTH = 1 << MAX_HISTORY_BITS;

  gbp_pkg::back_state_t state_r, state_nxt;

  logic [gbp_pkg::CTR_W-1:0]   ctr_mem [DEPTH];
  logic [gbp_pkg::CTR_W-1:0]   rd_data_r;
  logic [MAX_HISTORY_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [MAX_HISTORY_BITS-1:0] idx_r;
  logic                        taken_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        pred_r, mispred_r;

  logic                        mem_we, mem_re;
  logic [MAX_HISTORY_BITS-1:0] mem_waddr;
  logic [gbp_pkg::CTR_W-1:0]   mem_wdata;
  logic [gbp_pkg::CTR_W-1:0]   ctr_upd;
  logic                        latch_item, load_out;
  logic                        pred;

  assign pred = rd_data_r[1];

  always_comb begin
    if (taken_r) begin
      ctr_upd = (rd_data_r == gbp_pkg::CTR_MAX) ? rd_data_r : rd_data_r + gbp_pkg::CTR_STEP;
    end else begin
      ctr_upd = (rd_data_r == gbp_pkg::CTR_MIN) ? rd_data_r : rd_data_r - gbp_pkg::CTR_STEP;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clearing     = 1'b0;
    pop_ready    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = idx_r;
    mem_wdata    = ctr_upd;
    latch_item   = 1'b0;
    load_out     = 1'b0;
    unique case (state_r)
      gbp_pkg::B_CLEAR: begin
        clearing     = 1'b1;
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = gbp_pkg::CTR_INIT;
        clr_addr_nxt = clr_addr_r + MAX_HISTORY_BITS'(1);
        if (clr_addr_r == MAX_HISTORY_BITS'(DEPTH - 1)) begin
          state_nxt = gbp_pkg::B_IDLE;
        end
      end
      gbp_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          mem_re     = 1'b1;
          latch_item = 1'b1;
          state_nxt  = gbp_pkg::B_UPDATE;
        end
      end
      gbp_pkg::B_UPDATE: begin
        // hold the update until the output register can take the result
        if (!out_valid_r || out_ready) begin
          mem_we    = 1'b1;
          load_out  = 1'b1;
          state_nxt = gbp_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = gbp_pkg::B_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbp_pkg::B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (latch_item) begin
      idx_r   <= pop_data[MAX_HISTORY_BITS:1];
      taken_r <= pop_data[0];
    end
    if (load_out) begin
      pred_r    <= pred;
      mispred_r <= pred ^ taken_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ctr_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= ctr_mem[pop_data[MAX_HISTORY_BITS:1]];
    end
  end

  assign out_valid       = out_valid_r;
  assign predicted_taken = pred_r;
  assign mispredicted    = mispred_r;

endmodule
`default_nettype wire

@@ design/gshare_branch_predictor_unit.sv @@
// Gshare branch predictor top level.
// Flow: an accepted branch is written into the queue; the back end reads its
//   counter in the idle state, then writes it back and loads the output register
//   in the update state, and takes no new branch until that write is done.
// Reset: synchronous, active low; afterwards the table is swept to weakly taken,
//   with in_br.ready low during the sweep.
`timescale 1ns / 1ps
`default_nettype none
module gshare_branch_predictor_unit #(
  parameter int MAX_HISTORY_BITS = gbp_pkg::MAX_HISTORY_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [gbp_pkg::HIST_LEN_W-1:0] cfg_wdata,
  gbp_in_if.sink                              in_br,
  gbp_out_if.source                           out_res
);

  logic                      back_clearing;
  logic                      push_valid, push_ready;
  logic [MAX_HISTORY_BITS:0] push_data;
  logic                      pop_valid, pop_ready;
  logic [MAX_HISTORY_BITS:0] pop_data;

  gbp_front #(.MAX_HISTORY_BITS(MAX_HISTORY_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_br.valid),
    .in_ready      (in_br.ready),
    .branch_pc     (in_br.branch_pc),
    .actual_taken  (in_br.actual_taken),
    .back_clearing (back_clearing),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  gbp_queue #(
    .DATA_W (MAX_HISTORY_BITS + 1),
    .DEPTH  (gbp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gbp_back #(.MAX_HISTORY_BITS(MAX_HISTORY_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .clearing        (back_clearing),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_res.valid),
    .out_ready       (out_res.ready),
    .predicted_taken (out_res.predicted_taken),
    .mispredicted    (out_res.mispredicted)
  );

endmodule
`default_nettype wire

@@ design/gbp_checker.sv @@
// Port-level checker for the gshare predictor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gbp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic predicted_taken,
  input wire logic mispredicted
);

  logic [2:0] outstanding_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // track transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding_r <= outstanding_r + 3'd1;
    end else if (!in_acc && out_acc) begin
      outstanding_r <= outstanding_r - 3'd1;
    end
  end

  a_ready_low_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready high right after reset");

  a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(predicted_taken) && $stable(mispredicted))
    else $error("stalled result changed or dropped");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outstanding_r != 3'd0)
    else $error("result without an outstanding transaction");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= 3'd4)
    else $error("more transactions in flight than storage allows");

endmodule

bind gshare_branch_predictor_unit gbp_checker u_gbp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_br.valid),
  .in_ready        (in_br.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .predicted_taken (out_res.predicted_taken),
  .mispredicted    (out_res.mispredicted)
);
`default_nettype wire
